// ===== rtl/lidp_pkg.sv =====
// Shared types and constants for the line detect pulse indicator.
// Holds the pulse phase codes, opcodes, stream widths and the adder request type.
// No dependencies; imported by lidp_alu and line_detect_pulse_indicator_core.
package lidp_pkg;

   // Default number of sensors wired to the block
   localparam int SENSORS_DEF = 8;

   // Stream word widths
   localparam int REQ_DATA_W = 48;  // 8 + 4 + 32 bits, padded to whole bytes
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;  // 1 + 1 + 2 + 8 bits, padded to whole bytes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Saturation limits
   localparam logic [7:0]  QUEUE_MAX = 8'hFF;
   localparam logic [15:0] RUN_MAX   = 16'hFFFF;

   // Register reset values
   localparam logic [3:0]  ENTER_MIN_RST  = 4'd2;
   localparam logic [3:0]  EXIT_MAX_RST   = 4'd0;
   localparam logic [15:0] ENTER_CONF_RST = 16'd3;
   localparam logic [15:0] EXIT_CONF_RST  = 16'd5;
   localparam logic [15:0] ON_TIME_RST    = 16'd100;
   localparam logic [15:0] GAP_TIME_RST   = 16'd100;

   // Register indexes on the control port
   localparam logic [CSR_IDX_W-1:0] REG_ENTER_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENTER_CONF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_CONF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ON_TIME    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_TIME   = 3'd5;

   // Item opcodes
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_EDGE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // LED pulser phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   // Request to the shared 32-bit adder
   typedef struct packed {
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic        sub;
   } alu_req_type;

endpackage

// ===== rtl/lidp_alu.sv =====
// Shared 32-bit add/subtract unit for the pulse indicator sequencer.
// Serves deadline setup, the wrap-safe due test and deadline advance.
// Depends on lidp_pkg.
module lidp_alu (
   input  lidp_pkg::alu_req_type req,
   output logic [31:0]           sum
);
   import lidp_pkg::*;

   // Modulo 2^32 add or subtract
   assign sum = req.sub ? (req.op_a - req.op_b) : (req.op_a + req.op_b);

endmodule

// ===== rtl/line_detect_pulse_indicator_core.sv =====
// Line presence indicator: hysteresis debounce of sensor frames and a queued LED pulser.
// A frame counts min(sensor_count, SENSORS, 8) bits, one a cycle, classifies and, if the
// state flips, starts or queues a pulse; an edge starts or queues one; a tick takes each
// due phase transition (at most 512) in turn on the single shared 32-bit adder.
// One word in flight at a time; the next is taken once the result is in the output register.
// Synchronous active-high reset: registers back to defaults, pulser idle, no queued pulses.
module line_detect_pulse_indicator_core #(
   parameter int SENSORS = lidp_pkg::SENSORS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] sensor_bits, [11:8] sensor_count, [43:12] now_ms, [47:44] zero
   input  logic [lidp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] opcode
   input  logic [lidp_pkg::REQ_USER_W-1:0]   req_tuser,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] led_on, [1] line_present, [3:2] pulse_phase, [11:4] queued_pulses, [15:12] zero
   output logic [lidp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lidp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lidp_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lidp_pkg::*;

   // Valid bits per frame are limited by the sensors and the 8 carried bits
   localparam int         LIM_MAX = (SENSORS < 8) ? SENSORS : 8;
   localparam logic [3:0] LIM_W   = 4'(LIM_MAX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_CLASS,
      ST_START,
      ST_DUE,
      ST_STEP,
      ST_DONE
   } state_type;

   // Sequencer and item registers
   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [7:0]  bits_ff, bits_in;
   logic [3:0]  lim_ff, lim_in;
   logic [31:0] now_ff, now_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  active_ff, active_in;

   // Configuration registers
   logic [3:0]  enter_min_ff, enter_min_in;
   logic [3:0]  exit_max_ff, exit_max_in;
   logic [15:0] enter_conf_ff, enter_conf_in;
   logic [15:0] exit_conf_ff, exit_conf_in;
   logic [15:0] on_time_ff, on_time_in;
   logic [15:0] gap_time_ff, gap_time_in;

   // Debounce and pulser state
   phase_type   phase_ff, phase_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [7:0]  pending_ff, pending_in;
   logic        stable_ff, stable_in;
   logic        cand_ff, cand_in;
   logic [15:0] run_ff, run_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Classification helpers
   logic        present_hit;
   logic        absent_hit;
   logic [15:0] run_next;
   logic [15:0] need;
   logic [3:0]  count_req;

   alu_req_type alu_req;
   logic [31:0] alu_sum;

   lidp_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign count_req   = req_tdata[11:8];
   assign present_hit = (active_ff >= enter_min_ff);
   assign absent_hit  = (active_ff <= exit_max_ff);
   assign need        = present_hit ? enter_conf_ff : exit_conf_ff;
   assign run_next    = (present_hit != cand_ff) ? 16'd1 :
                        ((run_ff < RUN_MAX) ? (run_ff + 16'd1) : run_ff);

   // Operand select for the shared adder
   always_comb begin
      alu_req = '{op_a: now_ff, op_b: {16'd0, on_time_ff}, sub: 1'b0};
      case (state_ff)
         ST_DUE: begin
            alu_req = '{op_a: now_ff, op_b: deadline_ff, sub: 1'b1};
         end
         ST_STEP: begin
            alu_req = '{op_a: deadline_ff,
                        op_b: {16'd0, (phase_ff == PH_ON) ? gap_time_ff : on_time_ff},
                        sub: 1'b0};
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bits_in       = bits_ff;
      lim_in        = lim_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      enter_min_in  = enter_min_ff;
      exit_max_in   = exit_max_ff;
      enter_conf_in = enter_conf_ff;
      exit_conf_in  = exit_conf_ff;
      on_time_in    = on_time_ff;
      gap_time_in   = gap_time_ff;
      phase_in      = phase_ff;
      deadline_in   = deadline_ff;
      pending_in    = pending_ff;
      stable_in     = stable_ff;
      cand_in       = cand_ff;
      run_in        = run_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            REG_ENTER_MIN:  enter_min_in  = csr_data[3:0];
            REG_EXIT_MAX:   exit_max_in   = csr_data[3:0];
            REG_ENTER_CONF: enter_conf_in = csr_data;
            REG_EXIT_CONF:  exit_conf_in  = csr_data;
            REG_ON_TIME:    on_time_in    = csr_data;
            REG_GAP_TIME:   gap_time_in   = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               bits_in   = req_tdata[7:0];
               lim_in    = (count_req > LIM_W) ? LIM_W : count_req;
               now_in    = req_tdata[43:12];
               idx_in    = 4'd0;
               active_in = 4'd0;
               case (req_tuser)
                  OP_FRAME: state_in = ST_COUNT;
                  OP_EDGE:  state_in = ST_START;
                  OP_TICK:  state_in = ST_DUE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         // one sensor bit a cycle
         ST_COUNT: begin
            if (idx_ff < lim_ff) begin
               active_in = active_ff + {3'd0, bits_ff[idx_ff[2:0]]};
               idx_in    = idx_ff + 4'd1;
            end else begin
               state_in = ST_CLASS;
            end
         end
         // hysteresis and confirm count
         ST_CLASS: begin
            state_in = ST_DONE;
            if (!present_hit && !absent_hit) begin
               cand_in = stable_ff;
               run_in  = 16'd0;
            end else if (present_hit == stable_ff) begin
               cand_in = present_hit;
               run_in  = 16'd0;
            end else begin
               cand_in = present_hit;
               run_in  = run_next;
               if (run_next >= need) begin
                  stable_in = present_hit;
                  run_in    = 16'd0;
                  state_in  = ST_START;
               end
            end
         end
         // start a pulse, or queue the request unless the queue is full
         ST_START: begin
            state_in = ST_DONE;
            if (phase_ff == PH_IDLE) begin
               phase_in    = PH_ON;
               deadline_in = alu_sum;
            end else if (pending_ff < QUEUE_MAX) begin
               pending_in = pending_ff + 8'd1;
            end
         end
         // wrap-safe deadline test
         ST_DUE: begin
            if (phase_ff != PH_IDLE && !alu_sum[31]) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_DONE;
            end
         end
         // one phase transition
         ST_STEP: begin
            state_in = ST_DUE;
            if (phase_ff == PH_ON) begin
               if (pending_ff == 8'd0) begin
                  phase_in = PH_IDLE;
               end else begin
                  pending_in  = pending_ff - 8'd1;
                  phase_in    = PH_GAP;
                  deadline_in = alu_sum;
               end
            end else begin
               phase_in    = PH_ON;
               deadline_in = alu_sum;
            end
         end
         // hand the result over once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, pending_ff, phase_ff, stable_ff, phase_ff == PH_ON};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enter_min_ff  <= ENTER_MIN_RST;
         exit_max_ff   <= EXIT_MAX_RST;
         enter_conf_ff <= ENTER_CONF_RST;
         exit_conf_ff  <= EXIT_CONF_RST;
         on_time_ff    <= ON_TIME_RST;
         gap_time_ff   <= GAP_TIME_RST;
         phase_ff      <= PH_IDLE;
         deadline_ff   <= 32'd0;
         pending_ff    <= 8'd0;
         stable_ff     <= 1'b0;
         cand_ff       <= 1'b0;
         run_ff        <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enter_min_ff  <= enter_min_in;
         exit_max_ff   <= exit_max_in;
         enter_conf_ff <= enter_conf_in;
         exit_conf_ff  <= exit_conf_in;
         on_time_ff    <= on_time_in;
         gap_time_ff   <= gap_time_in;
         phase_ff      <= phase_in;
         deadline_ff   <= deadline_in;
         pending_ff    <= pending_in;
         stable_ff     <= stable_in;
         cand_ff       <= cand_in;
         run_ff        <= run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      bits_ff     <= bits_in;
      lim_ff      <= lim_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      active_ff   <= active_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Queue can only be non-empty while a pulse is running
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (pending_ff == 8'd0))
      else $error("queued pulses with pulser idle");

   // Candidate run is only counted while it differs from the stable state
   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (cand_ff == stable_ff) |-> (run_ff == 16'd0))
      else $error("run count left over on stable candidate");

   // LED flag agrees with the reported phase
   a_led_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:2] == PH_ON)))
      else $error("led flag disagrees with phase");

   // Only one word in flight
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   // Unused opcode word must not touch the debounce or pulser state
   a_nop_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff != OP_FRAME && op_ff != OP_EDGE && op_ff != OP_TICK)
      |-> ($stable(phase_ff) && $stable(pending_ff) && $stable(stable_ff)))
      else $error("unused opcode changed state");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for line_detect_pulse_indicator_core: directed rows, then random
// streams over several register settings, every result word checked against a predictor or a typed expectation.
// Depends on rtl/lidp_pkg.sv and rtl/line_detect_pulse_indicator_core.sv.
module tb;
   import lidp_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         N_SETTINGS     = 6;
   localparam int         RAND_PER_SET   = 36;
   localparam int         BURST_EDGES    = 260;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         DRAIN_CYCLES   = 12;

   // one result word, split into fields
   typedef struct {
      logic       led;
      logic       line;
      phase_type  phase;
      logic [7:0] queued;
   } ind_word_type;

   // one row of the directed table
   typedef struct {
      logic [1:0]   op;
      logic [7:0]   bits;
      logic [3:0]   cnt;
      logic [31:0]  t_ms;
      bit           typed;
      ind_word_type want;
   } dir_row_type;

   // one register setting and the clock value its stream starts from
   typedef struct {
      logic [3:0]  enter_min;
      logic [3:0]  exit_max;
      logic [15:0] enter_conf;
      logic [15:0] exit_conf;
      logic [15:0] on_ms;
      logic [15:0] gap_ms;
      logic [31:0] start_ms;
   } setting_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   line_detect_pulse_indicator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor copy of registers and state
   logic [3:0]  cf_enter;
   logic [3:0]  cf_exit;
   logic [15:0] cf_enconf;
   logic [15:0] cf_exconf;
   logic [15:0] cf_on;
   logic [15:0] cf_gap;
   phase_type   ph;
   logic [31:0] dl;
   logic [7:0]  pend;
   logic        stab;
   logic        cand;
   logic [15:0] run;

   ind_word_type want_q[$];
   dir_row_type  dir_q[$];
   int           n_fail    = 0;
   int           n_checked = 0;
   int           n_sent    = 0;
   bit           quiet     = 1'b0;
   bit           hold_req  = 1'b0;

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // start a pulse, or queue the request behind the running one
   task automatic queue_pulse(input logic [31:0] t_ms);
      if (ph == PH_IDLE) begin
         ph = PH_ON;
         dl = t_ms + {16'd0, cf_on};
      end else if (pend < QUEUE_MAX) begin
         pend = pend + 8'd1;
      end
   endtask

   // advance the predicted state by one word and return the expected result
   task automatic predict_indicator(input logic [1:0] op, input logic [7:0] bits,
                                    input logic [3:0] cnt, input logic [31:0] t_ms,
                                    output ind_word_type w);
      int          lim;
      int          active;
      logic        present;
      logic        classified;
      logic [15:0] need;
      logic [31:0] diff;
      case (op)
         OP_FRAME: begin
            lim = cnt;
            if (lim > SENSORS_DEF) lim = SENSORS_DEF;
            if (lim > 8) lim = 8;
            active = 0;
            for (int i = 0; i < lim; i++) active += bits[i];
            classified = 1'b1;
            present    = 1'b0;
            // present test first, so it wins on overlapping thresholds
            if (active >= cf_enter) present = 1'b1;
            else if (active <= cf_exit) present = 1'b0;
            else classified = 1'b0;
            if (!classified) begin
               cand = stab;
               run  = '0;
            end else if (present == stab) begin
               cand = present;
               run  = '0;
            end else begin
               if (present != cand) begin
                  cand = present;
                  run  = 16'd1;
               end else if (run < RUN_MAX) begin
                  run = run + 16'd1;
               end
               need = present ? cf_enconf : cf_exconf;
               if (run >= need) begin
                  stab = present;
                  run  = '0;
                  queue_pulse(t_ms);
               end
            end
         end
         OP_EDGE: queue_pulse(t_ms);
         OP_TICK: begin
            // catch up over every transition that is due, wrap-safe
            diff = t_ms - dl;
            while (ph != PH_IDLE && !diff[31]) begin
               if (ph == PH_ON) begin
                  if (pend == 8'd0) begin
                     ph = PH_IDLE;
                  end else begin
                     pend = pend - 8'd1;
                     ph   = PH_GAP;
                     dl   = dl + {16'd0, cf_gap};
                  end
               end else begin
                  ph = PH_ON;
                  dl = dl + {16'd0, cf_on};
               end
               diff = t_ms - dl;
            end
         end
         default: ;
      endcase
      w.led    = (ph == PH_ON);
      w.line   = stab;
      w.phase  = ph;
      w.queued = pend;
   endtask

   // offer one word; valid is left high, the caller lowers it
   task automatic send_word(input logic [1:0] op, input logic [7:0] bits,
                            input logic [3:0] cnt, input logic [31:0] t_ms,
                            input bit typed, input ind_word_type typed_want);
      ind_word_type w;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {4'd0, t_ms, cnt, bits};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_indicator(op, bits, cnt, t_ms, w);
      want_q.push_back(typed ? typed_want : w);
      n_sent++;
      @(negedge clock);
   endtask

   // register write; valid is left high, the caller lowers it
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ENTER_MIN:  cf_enter  = val[3:0];
         REG_EXIT_MAX:   cf_exit   = val[3:0];
         REG_ENTER_CONF: cf_enconf = val;
         REG_EXIT_CONF:  cf_exconf = val;
         REG_ON_TIME:    cf_on     = val;
         REG_GAP_TIME:   cf_gap    = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (want_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [7:0] bits, input logic [3:0] cnt,
                          input logic [31:0] t_ms, input bit typed, input logic led,
                          input logic line, input phase_type phase, input logic [7:0] queued);
      dir_row_type r;
      r.op          = op;
      r.bits        = bits;
      r.cnt         = cnt;
      r.t_ms        = t_ms;
      r.typed       = typed;
      r.want.led    = led;
      r.want.line   = line;
      r.want.phase  = phase;
      r.want.queued = queued;
      dir_q.push_back(r);
   endtask

   // receiver: random stalls, one long hold-off on request, none at the end
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin : rsp_check
      ind_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (want_q.size() == 0) begin
            $error("result word %h arrived with nothing expected", rsp_tdata);
            n_fail++;
         end else begin
            w = want_q.pop_front();
            n_checked++;
            if (rsp_tdata[0] !== w.led) begin
               $error("led_on: expected %0d, got %0d", w.led, rsp_tdata[0]);
               n_fail++;
            end
            if (rsp_tdata[1] !== w.line) begin
               $error("line_present: expected %0d, got %0d", w.line, rsp_tdata[1]);
               n_fail++;
            end
            if (rsp_tdata[3:2] !== w.phase) begin
               $error("pulse_phase: expected %0d, got %0d", w.phase, rsp_tdata[3:2]);
               n_fail++;
            end
            if (rsp_tdata[11:4] !== w.queued) begin
               $error("queued_pulses: expected %0d, got %0d", w.queued, rsp_tdata[11:4]);
               n_fail++;
            end
         end
      end
   end

   // stimulus
   initial begin
      ind_word_type none;
      dir_row_type  r;
      setting_type  st;
      logic [31:0]  sim_ms;
      logic [31:0]  sparse;
      logic [1:0]   op;
      logic [7:0]   bits;
      logic [3:0]   cnt;
      logic [31:0]  t_ms;
      bit           pat_hi;
      int           pick;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      none       = '{1'b0, 1'b0, PH_IDLE, 8'd0};
      pat_hi     = 1'b0;

      cf_enter  = ENTER_MIN_RST;
      cf_exit   = EXIT_MAX_RST;
      cf_enconf = ENTER_CONF_RST;
      cf_exconf = EXIT_CONF_RST;
      cf_on     = ON_TIME_RST;
      cf_gap    = GAP_TIME_RST;
      ph        = PH_IDLE;
      dl        = '0;
      pend      = '0;
      stab      = 1'b0;
      cand      = 1'b0;
      run       = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at reset settings; typed where the answer is plain
      add_row(OP_UNUSED, 8'hFF, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_TICK,   8'h00, 4'd0,  32'd0,         1'b1, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_EDGE,   8'h00, 4'd0,  32'd10,        1'b1, 1'b1, 1'b0, PH_ON,   8'd0);
      add_row(OP_EDGE,   8'hFF, 4'd8,  32'd20,        1'b1, 1'b1, 1'b0, PH_ON,   8'd1);
      // tick far "behind" through the wrap: not due yet
      add_row(OP_TICK,   8'h00, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_TICK,   8'h00, 4'd0,  32'd110,       1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_TICK,   8'h00, 4'd0,  32'd1000,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      // count clamp, then uncertain and absent frames reset the run
      add_row(OP_FRAME,  8'hFF, 4'd15, 32'd1000,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_FRAME,  8'h03, 4'd2,  32'd1001,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_FRAME,  8'h01, 4'd8,  32'd1002,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_FRAME,  8'hFF, 4'd0,  32'd1003,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      // three present frames confirm entry and start a pulse
      for (int i = 0; i < 3; i++)
         add_row(OP_FRAME, 8'hC0, 4'd8, 32'd1004 + i, 1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_FRAME,  8'hC0, 4'd7,  32'd1007,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      // five absent frames confirm exit, request is queued
      for (int i = 0; i < 5; i++)
         add_row(OP_FRAME, 8'h00, 4'd8, 32'd1008 + i, 1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_EDGE,   8'h00, 4'd0,  32'd1020,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      // time jump: several on and gap transitions in one tick
      add_row(OP_TICK,   8'h00, 4'd0,  32'd3000,      1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);
      add_row(OP_UNUSED, 8'h00, 4'd0,  32'd0,         1'b0, 1'b0, 1'b0, PH_IDLE, 8'd0);

      foreach (dir_q[i]) begin
         r = dir_q[i];
         send_word(r.op, r.bits, r.cnt, r.t_ms, r.typed, r.want);
      end

      // random streams, one per register setting
      for (int s = 0; s < N_SETTINGS; s++) begin
         case (s)
            0: st = '{4'd3, 4'd1, 16'd2,     16'd3,     16'd40,    16'd25,    32'd5000};
            1: st = '{4'd0, 4'd0, 16'd0,     16'd0,     16'd0,     16'd0,     32'd0};
            2: st = '{4'd8, 4'd8, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  32'hFFFF_0000};
            3: st = '{4'd2, 4'd6, 16'd1,     16'd1,     16'd7,     16'd3,     32'h7FFF_FF00};
            4: st = '{4'd8, 4'd0, 16'd1,     16'd2,     16'd20,    16'd10,    $urandom};
            default:
               st = '{4'd4, 4'd2, 16'd4,     16'd4,     16'd15,    16'd15,    32'hFFFF_FFC0};
         endcase
         wait_drained();
         csr_write(REG_ENTER_MIN,  {12'd0, st.enter_min});
         csr_write(REG_EXIT_MAX,   {12'd0, st.exit_max});
         csr_write(REG_ENTER_CONF, st.enter_conf);
         csr_write(REG_EXIT_CONF,  st.exit_conf);
         csr_write(REG_ON_TIME,    st.on_ms);
         csr_write(REG_GAP_TIME,   st.gap_ms);
         csr_valid <= 1'b0;
         sim_ms = st.start_ms;
         if (s == 0) hold_req = 1'b1;
         if (s == N_SETTINGS - 1) quiet = 1'b1;

         for (int k = 0; k < RAND_PER_SET; k++) begin
            pick = $urandom_range(0, 99);
            bits = '0;
            cnt  = '0;
            if (pick < 45) begin
               // sensor frames hold a pattern for a while so confirms can complete
               if ($urandom_range(0, 7) == 0) pat_hi = !pat_hi;
               sparse = $urandom & $urandom & $urandom;
               op     = OP_FRAME;
               bits   = pat_hi ? ~sparse[7:0] : sparse[7:0];
               cnt    = ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
               sim_ms = sim_ms + $urandom_range(0, 5);
               t_ms   = sim_ms;
            end else if (pick < 60) begin
               op     = OP_EDGE;
               sim_ms = sim_ms + $urandom_range(0, 5);
               t_ms   = sim_ms;
            end else if (pick < 95) begin
               op     = OP_TICK;
               sim_ms = sim_ms + $urandom_range(0, 40);
               if ($urandom_range(0, 19) == 0) sim_ms = sim_ms + $urandom;
               t_ms   = sim_ms;
            end else begin
               // noise: any opcode, any field value
               op   = 2'($urandom_range(0, 3));
               bits = 8'($urandom);
               cnt  = 4'($urandom_range(0, 15));
               t_ms = $urandom;
            end
            send_word(op, bits, cnt, t_ms, 1'b0, none);
         end

         // zero times: flood of edges saturates the queue, one tick drains it
         if (s == 1) begin
            for (int k = 0; k < BURST_EDGES; k++)
               send_word(OP_EDGE, 8'($urandom), 4'($urandom_range(0, 15)), sim_ms, 1'b0, none);
            send_word(OP_TICK, 8'h00, 4'd0, sim_ms, 1'b0, none);
         end
      end

      wait_drained();
      $display("Summary: %0d words over reset and %0d register settings, %0d results checked",
               n_sent, N_SETTINGS, n_checked);
      $display("Summary: %0d field mismatches or stray results", n_fail);
      if (n_fail == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
